// ===== rtl/pll_relock_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// pll relock sequencer assertion macros
// concurrent checks on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PLL_RELOCK_SEQUENCER_UNIT_ASSERT_SVH
`define PLL_RELOCK_SEQUENCER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define PRS_ASSERT(lbl, prop, msg)
`define PRS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/prs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg
// types and constants of the pll relock sequencer
// ----------------------------------------------------------------------------
package prs_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BYPASS,
		PH_POWER,
		PH_LOCK,
		PH_SETTLE_A,
		PH_SETTLE_B
	} phase_t;

	typedef logic [2:0] target_t;

	// write targets
	localparam target_t TGT_CTL0     = 3'd0;
	localparam target_t TGT_CTL1     = 3'd1;
	localparam target_t TGT_CTL2     = 3'd2;
	localparam target_t TGT_CTL3     = 3'd3;
	localparam target_t TGT_CTL5     = 3'd4;
	localparam target_t TGT_PD_EN    = 3'd5;
	localparam target_t TGT_CNT_EN   = 3'd6;
	localparam target_t TGT_REF_PER  = 3'd7;

	// configuration register indexes
	localparam logic [2:0] CFG_PLL_INDEX  = 3'd0;
	localparam logic [2:0] CFG_REF_DIV    = 3'd1;
	localparam logic [2:0] CFG_FB_DIV     = 3'd2;
	localparam logic [2:0] CFG_CTL2       = 3'd3;
	localparam logic [2:0] CFG_CTL3       = 3'd4;
	localparam logic [2:0] CFG_POSTDIV    = 3'd5;
	localparam logic [2:0] CFG_PD_MASK    = 3'd6;
	localparam logic [2:0] CFG_POLL_LIMIT = 3'd7;

	localparam logic [15:0] BYPASS_SETTLE_US  = 16'd3;
	localparam logic [15:0] POWER_UP_DELAY_US = 16'd5;
	localparam logic [15:0] SETTLE_US         = 16'd300;

	localparam logic [4:0]  BYPASS_BIT         = 5'h10;
	localparam logic [4:0]  POWER_BIT          = 5'h02;
	localparam logic [31:0] REFCLK_PERIOD      = 32'd1000;
	localparam logic [31:0] COUNTER_ENABLE_ALL = 32'h0000_00ff;

	// reset values of the configuration registers
	localparam logic [2:0]  RST_PLL_INDEX  = 3'd0;
	localparam logic [7:0]  RST_REF_DIV    = 8'd2;
	localparam logic [15:0] RST_FB_DIV     = 16'd128;
	localparam logic [31:0] RST_CTL2       = 32'h0000_0018;
	localparam logic [31:0] RST_CTL3       = 32'd1;
	localparam logic [31:0] RST_POSTDIV    = 32'd3;
	localparam logic [7:0]  RST_PD_MASK    = 8'd15;
	localparam logic [15:0] RST_POLL_LIMIT = 16'd400;

endpackage

// ===== rtl/prs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_in_if
// input channel: start request, microsecond tick, lock status
// ----------------------------------------------------------------------------
interface prs_in_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic       tick_us;
	logic [4:0] lock_bits;

	modport source (output valid, start_req, tick_us, lock_bits, input ready);
	modport sink (input valid, start_req, tick_us, lock_bits, output ready);
endinterface

// ===== rtl/prs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_out_if
// result channel: one register write or status word per transfer
// ----------------------------------------------------------------------------
interface prs_out_if;
	logic        valid;
	logic        ready;
	logic        write_valid;
	logic [2:0]  write_target;
	logic [31:0] write_data;
	logic        busy_res;
	logic        done_res;
	logic        lock_timed_out;
	logic        last;

	modport source (output valid, write_valid, write_target, write_data, busy_res,
		done_res, lock_timed_out, last, input ready);
	modport sink (input valid, write_valid, write_target, write_data, busy_res,
		done_res, lock_timed_out, last, output ready);
endinterface

// ===== rtl/prs_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface prs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pll_relock_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_relock_sequencer_unit
// sequences the reprogramming of one pll as register writes
// ----------------------------------------------------------------------------
//  channel     dir  handshake     payload
//  item_in     in   valid/ready   start_req, tick_us, lock_bits
//  result_out  out  valid/ready   write_valid .. last
//  cfg         in   valid/ready   index, data (always ready)
//
// an item is registered, evaluated against the sequencer state in one pass and
// its one to four result words are held in a pack register that drains one word
// per cycle, while the output is ready, through the output register; the first
// word passes the input, pack and output registers on its way to the port
// an item with n result words holds the output port for n transfers, so items
// that cause a single word flow one per cycle while the output is ready
// arst_n clears the state and valid flags and resets the configuration registers
// a stalled output holds its word while the next item is still taken in
// ----------------------------------------------------------------------------
`include "pll_relock_sequencer_unit_assert.svh"

module pll_relock_sequencer_unit (
	input  logic     clk,
	input  logic     arst_n,
	prs_in_if.sink   item_in,
	prs_out_if.source result_out,
	prs_cfg_if.sink  cfg
);

	// configuration registers
	logic [2:0]  pll_index_q;
	logic [7:0]  ref_divider_q;
	logic [15:0] feedback_divider_q;
	logic [31:0] control_two_word_q;
	logic [31:0] control_three_word_q;
	logic [31:0] postdiv_word_q;
	logic [7:0]  postdiv_enable_mask_q;
	logic [15:0] lock_poll_limit_q;

	// sequencer state
	prs_pkg::phase_t phase_q, phase_d;
	logic [15:0]     wait_q, wait_d;
	logic [4:0]      shadow_q, shadow_d;
	logic            tmo_q, tmo_d;

	// input stage
	logic       vld_s1;
	logic       start_s1;
	logic       tick_s1;
	logic [4:0] lock_s1;

	// result pack
	logic                 vld_s2;
	logic [1:0]           cnt_s2;
	logic [1:0]           idx_s2;
	logic                 wv_s2;
	prs_pkg::target_t     tgt_s2 [4];
	logic [31:0]          data_s2 [4];
	logic                 busy_s2;
	logic                 done_s2;
	logic                 tmo_s2;

	// output register
	logic        vld_s3;
	logic        wv_s3;
	logic [2:0]  tgt_s3;
	logic [31:0] data_s3;
	logic        busy_s3;
	logic        done_s3;
	logic        tmo_s3;
	logic        last_s3;

	// pass results
	logic             res_wv;
	logic [1:0]       res_cnt;
	prs_pkg::target_t res_tgt [4];
	logic [31:0]      res_data [4];
	logic             res_done;

	logic        in_acc;
	logic        s1_fire;
	logic        pk_last;
	logic        out_load;
	logic        pk_free;
	logic [15:0] wc1;
	logic [15:0] tick_len;
	logic        tick_done;
	logic [7:0]  lock_wide;
	logic        lock_hit;
	logic        start_go;

	// ---------------- handshakes ----------------
	assign pk_last   = (idx_s2 == cnt_s2);
	assign out_load  = vld_s2 && (!vld_s3 || result_out.ready);
	assign pk_free   = !vld_s2 || (out_load && pk_last);
	assign s1_fire   = vld_s1 && pk_free;
	assign item_in.ready = !vld_s1 || pk_free;
	assign in_acc    = item_in.valid && item_in.ready;
	assign cfg.ready = 1'b1;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pll_index_q           <= prs_pkg::RST_PLL_INDEX;
			ref_divider_q         <= prs_pkg::RST_REF_DIV;
			feedback_divider_q    <= prs_pkg::RST_FB_DIV;
			control_two_word_q    <= prs_pkg::RST_CTL2;
			control_three_word_q  <= prs_pkg::RST_CTL3;
			postdiv_word_q        <= prs_pkg::RST_POSTDIV;
			postdiv_enable_mask_q <= prs_pkg::RST_PD_MASK;
			lock_poll_limit_q     <= prs_pkg::RST_POLL_LIMIT;
		end else if (cfg.valid) begin
			case (cfg.index)
				prs_pkg::CFG_PLL_INDEX:  pll_index_q           <= cfg.data[2:0];
				prs_pkg::CFG_REF_DIV:    ref_divider_q         <= cfg.data[7:0];
				prs_pkg::CFG_FB_DIV:     feedback_divider_q    <= cfg.data[15:0];
				prs_pkg::CFG_CTL2:       control_two_word_q    <= cfg.data;
				prs_pkg::CFG_CTL3:       control_three_word_q  <= cfg.data;
				prs_pkg::CFG_POSTDIV:    postdiv_word_q        <= cfg.data;
				prs_pkg::CFG_PD_MASK:    postdiv_enable_mask_q <= cfg.data[7:0];
				prs_pkg::CFG_POLL_LIMIT: lock_poll_limit_q     <= cfg.data[15:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------- input stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			start_s1 <= item_in.start_req;
			tick_s1  <= item_in.tick_us;
			lock_s1  <= item_in.lock_bits;
		end
	end

	// ---------------- shared wait counter ----------------
	assign wc1 = wait_q + 16'd1;

	always_comb begin
		case (phase_q)
			prs_pkg::PH_BYPASS:   tick_len = prs_pkg::BYPASS_SETTLE_US;
			prs_pkg::PH_POWER:    tick_len = prs_pkg::POWER_UP_DELAY_US;
			prs_pkg::PH_LOCK:     tick_len = lock_poll_limit_q;
			default:              tick_len = prs_pkg::SETTLE_US;
		endcase
	end

	assign tick_done = tick_s1 && (wc1 >= tick_len);

	// pll indexes above four select no lock bit
	assign lock_wide = {3'b000, lock_s1};
	assign lock_hit  = lock_wide[pll_index_q];

	// ---------------- next state ----------------
	always_comb begin
		phase_d  = phase_q;
		wait_d   = wait_q;
		shadow_d = shadow_q;
		tmo_d    = tmo_q;
		case (phase_q)
			prs_pkg::PH_IDLE: begin
				if (start_s1) begin
					tmo_d    = 1'b0;
					wait_d   = '0;
					shadow_d = shadow_q & ~prs_pkg::BYPASS_BIT;
					phase_d  = prs_pkg::PH_BYPASS;
				end
			end
			prs_pkg::PH_BYPASS, prs_pkg::PH_POWER, prs_pkg::PH_SETTLE_A,
			prs_pkg::PH_SETTLE_B: begin
				if (tick_done) begin
					wait_d = '0;
					case (phase_q)
						prs_pkg::PH_BYPASS: begin
							shadow_d = '0;
							phase_d  = prs_pkg::PH_POWER;
						end
						prs_pkg::PH_POWER: begin
							shadow_d = shadow_q | prs_pkg::POWER_BIT;
							phase_d  = prs_pkg::PH_LOCK;
						end
						prs_pkg::PH_SETTLE_A: begin
							shadow_d = shadow_q | prs_pkg::BYPASS_BIT;
							phase_d  = prs_pkg::PH_SETTLE_B;
						end
						default: phase_d = prs_pkg::PH_IDLE;
					endcase
				end else if (tick_s1) begin
					wait_d = wc1;
				end
			end
			prs_pkg::PH_LOCK: begin
				if (lock_hit) begin
					wait_d  = '0;
					phase_d = prs_pkg::PH_SETTLE_A;
				end else if (tick_done) begin
					tmo_d   = 1'b1;
					wait_d  = '0;
					phase_d = prs_pkg::PH_SETTLE_A;
				end else if (tick_s1) begin
					wait_d = wc1;
				end
			end
			default: begin
				phase_d = prs_pkg::PH_IDLE;
				wait_d  = '0;
			end
		endcase
	end

	// ---------------- result words ----------------
	always_comb begin
		res_wv   = 1'b0;
		res_cnt  = 2'd0;
		res_done = 1'b0;
		for (int k = 0; k < 4; k++) begin
			res_tgt[k]  = prs_pkg::TGT_CTL0;
			res_data[k] = '0;
		end
		case (phase_q)
			prs_pkg::PH_IDLE: begin
				if (start_s1) begin
					res_wv      = 1'b1;
					res_data[0] = {27'd0, shadow_q & ~prs_pkg::BYPASS_BIT};
				end
			end
			prs_pkg::PH_BYPASS: begin
				if (tick_done) begin
					res_wv      = 1'b1;
					res_cnt     = 2'd3;
					res_tgt[1]  = prs_pkg::TGT_CTL1;
					res_data[1] = {feedback_divider_q, 8'd0, ref_divider_q};
					res_tgt[2]  = prs_pkg::TGT_CTL2;
					res_data[2] = control_two_word_q;
					res_tgt[3]  = prs_pkg::TGT_CTL3;
					res_data[3] = control_three_word_q;
				end
			end
			prs_pkg::PH_POWER: begin
				if (tick_done) begin
					res_wv      = 1'b1;
					res_data[0] = {27'd0, shadow_q | prs_pkg::POWER_BIT};
				end
			end
			prs_pkg::PH_LOCK: begin
				if (lock_hit || tick_done) begin
					res_wv      = 1'b1;
					res_cnt     = 2'd2;
					res_tgt[0]  = prs_pkg::TGT_PD_EN;
					res_tgt[1]  = prs_pkg::TGT_CTL5;
					res_data[1] = postdiv_word_q;
					res_tgt[2]  = prs_pkg::TGT_PD_EN;
					res_data[2] = {24'd0, postdiv_enable_mask_q};
				end
			end
			prs_pkg::PH_SETTLE_A: begin
				if (tick_done) begin
					res_wv      = 1'b1;
					res_data[0] = {27'd0, shadow_q | prs_pkg::BYPASS_BIT};
				end
			end
			prs_pkg::PH_SETTLE_B: begin
				if (tick_done) begin
					res_wv      = 1'b1;
					res_cnt     = 2'd1;
					res_done    = 1'b1;
					res_tgt[0]  = prs_pkg::TGT_REF_PER;
					res_data[0] = prs_pkg::REFCLK_PERIOD;
					res_tgt[1]  = prs_pkg::TGT_CNT_EN;
					res_data[1] = prs_pkg::COUNTER_ENABLE_ALL;
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------- state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= prs_pkg::PH_IDLE;
			wait_q   <= '0;
			shadow_q <= '0;
			tmo_q    <= 1'b0;
		end else if (s1_fire) begin
			phase_q  <= phase_d;
			wait_q   <= wait_d;
			shadow_q <= shadow_d;
			tmo_q    <= tmo_d;
		end
	end

	// ---------------- result pack ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			idx_s2 <= '0;
		end else if (s1_fire) begin
			vld_s2 <= 1'b1;
			idx_s2 <= '0;
		end else if (out_load) begin
			if (pk_last) begin
				vld_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			cnt_s2  <= res_cnt;
			wv_s2   <= res_wv;
			tgt_s2  <= res_tgt;
			data_s2 <= res_data;
			busy_s2 <= (phase_d != prs_pkg::PH_IDLE);
			done_s2 <= res_done;
			tmo_s2  <= tmo_d;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (out_load) begin
			vld_s3 <= 1'b1;
		end else if (result_out.ready) begin
			vld_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			wv_s3   <= wv_s2;
			tgt_s3  <= tgt_s2[idx_s2];
			data_s3 <= data_s2[idx_s2];
			busy_s3 <= busy_s2;
			done_s3 <= done_s2;
			tmo_s3  <= tmo_s2;
			last_s3 <= pk_last;
		end
	end

	assign result_out.valid          = vld_s3;
	assign result_out.write_valid    = wv_s3;
	assign result_out.write_target   = tgt_s3;
	assign result_out.write_data     = data_s3;
	assign result_out.busy_res       = busy_s3;
	assign result_out.done_res       = done_s3;
	assign result_out.lock_timed_out = tmo_s3;
	assign result_out.last           = last_s3;

	// ---------------- checks ----------------
	assign start_go = s1_fire && (phase_q == prs_pkg::PH_IDLE) && start_s1;

	`PRS_ASSERT_IMP(a_idx_in_pack, vld_s2, idx_s2 <= cnt_s2, "pack index past word count")
	`PRS_ASSERT_IMP(a_done_not_busy, vld_s3 && done_s3, !busy_s3, "done word still busy")
	`PRS_ASSERT(a_start_bypass, start_go |=> phase_q == prs_pkg::PH_BYPASS, "no bypass after start")
	`PRS_ASSERT_IMP(a_bypass_wait, phase_q == prs_pkg::PH_BYPASS, wait_q < prs_pkg::BYPASS_SETTLE_US, "bypass wait overran")
	`PRS_ASSERT_IMP(a_no_overwrite, vld_s1 && !s1_fire, !item_in.ready, "input stage overwritten")

endmodule

// ===== tb/prs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_checker
// watches the item, result and register channels of the pll relock sequencer,
// predicts every result word from its own copy of the state and compares
// ----------------------------------------------------------------------------
module prs_checker (
	input  logic clk,
	input  logic arst_n,
	prs_in_if    item_mon,
	prs_out_if   res_mon,
	prs_cfg_if   cfg_mon,
	output int   pending,
	output int   mismatches,
	output int   items_seen,
	output int   words_seen,
	output int   seq_done,
	output int   lock_tmos
);
	import prs_pkg::*;

	typedef struct packed {
		logic        wr;
		logic [2:0]  tgt;
		logic [31:0] data;
		logic        busy;
		logic        done;
		logic        tmo;
		logic        last;
	} word_t;

	word_t       expected_q[$];
	logic [2:0]  tgt_q[$];
	logic [31:0] data_q[$];
	word_t       got_w;
	word_t       want_w;

	// register copy
	logic [2:0]  sel_idx;
	logic [7:0]  ref_div;
	logic [15:0] fb_div;
	logic [31:0] ctl2_word;
	logic [31:0] ctl3_word;
	logic [31:0] postdiv_word;
	logic [7:0]  pd_mask;
	logic [15:0] poll_limit;

	// sequencer state
	phase_t      seq_phase;
	logic [15:0] us_count;
	logic [4:0]  ctl0_shadow;
	logic        tmo_flag;

	int n_items;
	int n_words;
	int n_done;
	int n_tmo;
	int n_bad;

	function automatic void add_write(input logic [2:0] t, input logic [31:0] d);
		tgt_q.push_back(t);
		data_q.push_back(d);
	endfunction

	function automatic void write_ctl0(input logic [4:0] v);
		ctl0_shadow = v;
		add_write(TGT_CTL0, {27'd0, v});
	endfunction

	// only ticks of items after the one that armed the wait are counted
	function automatic logic us_elapsed(input logic tk, input logic [15:0] len);
		if (!tk)
			return 1'b0;
		us_count = us_count + 16'd1;
		if (us_count >= len) begin
			us_count = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void load_postdivs();
		add_write(TGT_PD_EN, 32'd0);
		add_write(TGT_CTL5, postdiv_word);
		add_write(TGT_PD_EN, {24'd0, pd_mask});
		us_count = '0;
		seq_phase = PH_SETTLE_A;
	endfunction

	function automatic void step_item(input logic st, input logic tk, input logic [4:0] lk);
		logic [7:0] lk_wide;
		logic       fin;
		word_t      w;
		int         n;
		tgt_q.delete();
		data_q.delete();
		fin = 1'b0;
		// an index of 5 to 7 shifts every lock bit out
		lk_wide = {3'b000, lk} >> sel_idx;
		case (seq_phase)
			PH_IDLE: begin
				if (st) begin
					tmo_flag = 1'b0;
					us_count = '0;
					write_ctl0(ctl0_shadow & ~BYPASS_BIT);
					seq_phase = PH_BYPASS;
				end
			end
			PH_BYPASS: begin
				if (us_elapsed(tk, BYPASS_SETTLE_US)) begin
					write_ctl0(5'd0);
					add_write(TGT_CTL1, {fb_div, 8'd0, ref_div});
					add_write(TGT_CTL2, ctl2_word);
					add_write(TGT_CTL3, ctl3_word);
					seq_phase = PH_POWER;
				end
			end
			PH_POWER: begin
				if (us_elapsed(tk, POWER_UP_DELAY_US)) begin
					write_ctl0(ctl0_shadow | POWER_BIT);
					seq_phase = PH_LOCK;
				end
			end
			PH_LOCK: begin
				if (lk_wide[0]) begin
					load_postdivs();
				end else if (us_elapsed(tk, poll_limit)) begin
					tmo_flag = 1'b1;
					n_tmo++;
					load_postdivs();
				end
			end
			PH_SETTLE_A: begin
				if (us_elapsed(tk, SETTLE_US)) begin
					write_ctl0(ctl0_shadow | BYPASS_BIT);
					seq_phase = PH_SETTLE_B;
				end
			end
			PH_SETTLE_B: begin
				if (us_elapsed(tk, SETTLE_US)) begin
					add_write(TGT_REF_PER, REFCLK_PERIOD);
					add_write(TGT_CNT_EN, COUNTER_ENABLE_ALL);
					seq_phase = PH_IDLE;
					us_count = '0;
					fin = 1'b1;
				end
			end
			default: begin
				seq_phase = PH_IDLE;
				us_count = '0;
			end
		endcase
		n = (tgt_q.size() > 0) ? tgt_q.size() : 1;
		for (int k = 0; k < n; k++) begin
			w.wr   = (k < tgt_q.size());
			w.tgt  = w.wr ? tgt_q[k] : 3'd0;
			w.data = w.wr ? data_q[k] : 32'd0;
			w.busy = (seq_phase != PH_IDLE);
			w.done = fin;
			w.tmo  = tmo_flag;
			w.last = (k == n - 1);
			expected_q.push_back(w);
		end
		n_items++;
		if (fin)
			n_done++;
	endfunction

	function automatic void report_word(input string why, input word_t e, input word_t g);
		n_bad++;
		if (n_bad <= 10) begin
			$display("mismatch %0d at result word %0d, %s", n_bad, n_words, why);
			$display("  expected wr=%0b tgt=%0d data=%h busy=%0b done=%0b tmo=%0b last=%0b",
				e.wr, e.tgt, e.data, e.busy, e.done, e.tmo, e.last);
			$display("  actual   wr=%0b tgt=%0d data=%h busy=%0b done=%0b tmo=%0b last=%0b",
				g.wr, g.tgt, g.data, g.busy, g.done, g.tmo, g.last);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			sel_idx      = RST_PLL_INDEX;
			ref_div      = RST_REF_DIV;
			fb_div       = RST_FB_DIV;
			ctl2_word    = RST_CTL2;
			ctl3_word    = RST_CTL3;
			postdiv_word = RST_POSTDIV;
			pd_mask      = RST_PD_MASK;
			poll_limit   = RST_POLL_LIMIT;
			seq_phase    = PH_IDLE;
			us_count     = '0;
			ctl0_shadow  = '0;
			tmo_flag     = 1'b0;
			n_items      = 0;
			n_words      = 0;
			n_done       = 0;
			n_tmo        = 0;
			n_bad        = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_mon.index)
					CFG_PLL_INDEX:  sel_idx      = cfg_mon.data[2:0];
					CFG_REF_DIV:    ref_div      = cfg_mon.data[7:0];
					CFG_FB_DIV:     fb_div       = cfg_mon.data[15:0];
					CFG_CTL2:       ctl2_word    = cfg_mon.data;
					CFG_CTL3:       ctl3_word    = cfg_mon.data;
					CFG_POSTDIV:    postdiv_word = cfg_mon.data;
					CFG_PD_MASK:    pd_mask      = cfg_mon.data[7:0];
					CFG_POLL_LIMIT: poll_limit   = cfg_mon.data[15:0];
					default: ;
				endcase
			end
			if (item_mon.valid && item_mon.ready)
				step_item(item_mon.start_req, item_mon.tick_us, item_mon.lock_bits);
			if (res_mon.valid && res_mon.ready) begin
				got_w.wr   = res_mon.write_valid;
				got_w.tgt  = res_mon.write_target;
				got_w.data = res_mon.write_data;
				got_w.busy = res_mon.busy_res;
				got_w.done = res_mon.done_res;
				got_w.tmo  = res_mon.lock_timed_out;
				got_w.last = res_mon.last;
				if (expected_q.size() == 0) begin
					report_word("word arrived with nothing expected", '0, got_w);
				end else begin
					want_w = expected_q.pop_front();
					if (got_w.wr !== want_w.wr || got_w.tgt !== want_w.tgt
							|| got_w.data !== want_w.data || got_w.busy !== want_w.busy
							|| got_w.done !== want_w.done || got_w.tmo !== want_w.tmo
							|| got_w.last !== want_w.last)
						report_word("field differs", want_w, got_w);
				end
				n_words++;
			end
		end
		pending    <= expected_q.size();
		mismatches <= n_bad;
		items_seen <= n_items;
		words_seen <= n_words;
		seq_done   <= n_done;
		lock_tmos  <= n_tmo;
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random relock sequences into the pll relock sequencer
// under several register settings, with random gaps on the item channel and
// result stalls; prs_checker predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_top;
	import prs_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 360;
	localparam int PHASE_ITEMS  = 90;
	localparam int STALL_CYCLES = 400;
	localparam int DRAIN_CYCLES = 24;

	typedef enum int {
		SET_DIRECTED,
		SET_RESET,
		SET_HIGH,
		SET_LOW,
		SET_RANDOM
	} setting_kind_t;

	typedef struct {
		logic [2:0]  pll_idx;
		logic [7:0]  ref_div;
		logic [15:0] fb_div;
		logic [31:0] ctl2;
		logic [31:0] ctl3;
		logic [31:0] postdiv;
		logic [7:0]  pd_mask;
		logic [15:0] poll;
		int          clear_pct;
	} setting_t;

	logic     clk;
	logic     arst_n;
	int       cycle_cnt;
	int       stall_asks;
	int       n_settings;
	setting_t cur;

	int pending;
	int mismatches;
	int items_seen;
	int words_seen;
	int seq_done;
	int lock_tmos;

	prs_in_if  in_if ();
	prs_out_if out_if ();
	prs_cfg_if cfg_if ();

	pll_relock_sequencer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (in_if),
		.result_out (out_if),
		.cfg        (cfg_if)
	);

	prs_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_mon   (in_if),
		.res_mon    (out_if),
		.cfg_mon    (cfg_if),
		.pending    (pending),
		.mismatches (mismatches),
		.items_seen (items_seen),
		.words_seen (words_seen),
		.seq_done   (seq_done),
		.lock_tmos  (lock_tmos)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAIL");
		$finish;
	end

	function automatic setting_t make_setting(input setting_kind_t kind);
		setting_t s;
		s.pll_idx   = RST_PLL_INDEX;
		s.ref_div   = RST_REF_DIV;
		s.fb_div    = RST_FB_DIV;
		s.ctl2      = RST_CTL2;
		s.ctl3      = RST_CTL3;
		s.postdiv   = RST_POSTDIV;
		s.pd_mask   = RST_PD_MASK;
		s.poll      = RST_POLL_LIMIT;
		s.clear_pct = 60;
		case (kind)
			SET_DIRECTED: begin
				s.pll_idx   = 3'd3;
				s.poll      = 16'd2;
				s.clear_pct = 0;
			end
			SET_HIGH: begin
				s.pll_idx   = 3'd4;
				s.ref_div   = '1;
				s.fb_div    = '1;
				s.ctl2      = '1;
				s.ctl3      = '1;
				s.postdiv   = '1;
				s.pd_mask   = '1;
				s.poll      = '1;
				s.clear_pct = 50;
			end
			SET_LOW: begin
				// no lock bit selected and a zero limit: times out on the first tick
				s.pll_idx = 3'd7;
				s.ref_div = '0;
				s.fb_div  = '0;
				s.ctl2    = '0;
				s.ctl3    = '0;
				s.postdiv = '0;
				s.pd_mask = '0;
				s.poll    = '0;
			end
			SET_RANDOM: begin
				s.pll_idx   = 3'($urandom_range(0, 7));
				s.ref_div   = 8'($urandom());
				s.fb_div    = 16'($urandom());
				s.ctl2      = $urandom();
				s.ctl3      = $urandom();
				s.postdiv   = $urandom();
				s.pd_mask   = 8'($urandom());
				s.poll      = 16'($urandom_range(1, 24));
				s.clear_pct = $urandom_range(50, 100);
			end
			default: ;
		endcase
		return s;
	endfunction

	// leaves valid high so that writes can follow back to back
	task automatic cfg_put(input logic [2:0] idx, input logic [31:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	// unused upper bits carry noise
	task automatic apply_setting(input setting_t s);
		logic [31:0] junk;
		junk = $urandom();
		cfg_put(CFG_PLL_INDEX, {junk[31:3], s.pll_idx});
		junk = $urandom();
		cfg_put(CFG_REF_DIV, {junk[31:8], s.ref_div});
		junk = $urandom();
		cfg_put(CFG_FB_DIV, {junk[31:16], s.fb_div});
		cfg_put(CFG_CTL2, s.ctl2);
		cfg_put(CFG_CTL3, s.ctl3);
		cfg_put(CFG_POSTDIV, s.postdiv);
		junk = $urandom();
		cfg_put(CFG_PD_MASK, {junk[31:8], s.pd_mask});
		junk = $urandom();
		cfg_put(CFG_POLL_LIMIT, {junk[31:16], s.poll});
		cfg_if.valid <= 1'b0;
		cur = s;
		n_settings++;
	endtask

	task automatic send_item(input logic st, input logic tk, input logic [4:0] lk);
		in_if.valid     <= 1'b1;
		in_if.start_req <= st;
		in_if.tick_us   <= tk;
		in_if.lock_bits <= lk;
		do @(posedge clk); while (!in_if.ready);
	endtask

	task automatic idle_gap(input logic burst);
		int r;
		int g;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			g = 0;
		else if (r < 94)
			g = $urandom_range(1, 3);
		else
			g = $urandom_range(15, 60);
		if (g > 0) begin
			in_if.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// result side: random ready with steady stretches, plus long holds on request
	initial begin
		int stall_taken;
		int seg_left;
		int r;
		logic steady;
		stall_taken = 0;
		seg_left = 0;
		steady = 1'b0;
		out_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_asks != stall_taken) begin
				stall_taken++;
				out_if.ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(8, 60);
					steady = ($urandom_range(0, 3) == 0);
				end
				seg_left--;
				r = $urandom_range(0, 99);
				if (steady || r < 65) begin
					out_if.ready <= 1'b1;
					@(posedge clk);
				end else if (r < 96) begin
					out_if.ready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					out_if.ready <= 1'b0;
					repeat ($urandom_range(20, 80)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int rand_items;
		int ph;
		int tick_pct;
		logic burst;
		logic st;
		logic tk;
		logic [4:0] lk;
		stall_asks = 0;
		n_settings = 0;
		tick_pct = 90;
		burst = 1'b0;
		arst_n          <= 1'b0;
		in_if.valid     <= 1'b0;
		in_if.start_req <= 1'b0;
		in_if.tick_us   <= 1'b0;
		in_if.lock_bits <= '0;
		cfg_if.valid    <= 1'b0;
		cfg_if.index    <= CFG_PLL_INDEX;
		cfg_if.data     <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk: lock bit 3, poll limit 2
		apply_setting(make_setting(SET_DIRECTED));
		send_item(1'b0, 1'b1, 5'h1f);    // idle, tick ignored
		idle_gap(1'b0);
		send_item(1'b0, 1'b0, 5'h00);
		idle_gap(1'b0);
		send_item(1'b1, 1'b1, 5'h00);    // start, its own tick not counted
		idle_gap(1'b0);
		send_item(1'b1, 1'b1, 5'h00);    // start while busy
		idle_gap(1'b0);
		send_item(1'b0, 1'b0, 5'h1f);
		idle_gap(1'b0);
		send_item(1'b0, 1'b1, 5'h00);
		idle_gap(1'b0);
		send_item(1'b1, 1'b1, 5'h00);    // third tick: control words
		idle_gap(1'b0);
		repeat (4) begin
			send_item(1'b0, 1'b1, 5'h00);
			idle_gap(1'b0);
		end
		send_item(1'b0, 1'b1, 5'h08);    // power-up word; lock here is not sampled
		idle_gap(1'b0);
		send_item(1'b0, 1'b0, 5'h17);    // lock sampled, own bit clear
		idle_gap(1'b0);
		send_item(1'b0, 1'b1, 5'h17);
		idle_gap(1'b0);
		send_item(1'b0, 1'b1, 5'h00);    // poll limit reached: timeout and post-divider load
		idle_gap(1'b0);
		send_item(1'b0, 1'b1, 5'h1f);    // timeout flag stays up while settling
		idle_gap(1'b0);

		rand_items = 0;
		ph = 0;
		while (rand_items < RANDOM_ITEMS) begin
			in_if.valid <= 1'b0;
			wait_drained();
			apply_setting(make_setting(setting_kind_t'(SET_RESET + ph % 4)));
			// hold off the result side while items keep coming
			if (ph == 1)
				stall_asks++;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 40 == 0) begin
					tick_pct = ($urandom_range(0, 4) == 0) ? 25 : 90;
					burst = (ph == 1 && k == 0) || ($urandom_range(0, 3) == 0);
				end
				st = ($urandom_range(0, 99) < 6);
				tk = ($urandom_range(0, 99) < tick_pct);
				lk = 5'($urandom_range(0, 31));
				if (cur.pll_idx < 5 && $urandom_range(0, 99) < cur.clear_pct)
					lk[cur.pll_idx] = 1'b0;
				send_item(st, tk, lk);
				idle_gap(burst);
				rand_items++;
			end
			ph++;
		end

		in_if.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d items and %0d result words under %0d register settings",
			items_seen, words_seen, n_settings);
		$display("%0d relock sequences ran to the end, %0d lock waits timed out",
			seq_done, lock_tmos);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/prs_pkg.sv
rtl/prs_in_if.sv
rtl/prs_out_if.sv
rtl/prs_cfg_if.sv
rtl/pll_relock_sequencer_unit.sv
tb/prs_checker.sv
tb/tb_top.sv
